// ----- hdl/elb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Elliptic light blend package
// Word types of the pixel and result channels and the register indexes of
// the configuration port.
// ----------------------------------------------------------------------------
package elb_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 10;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPOT_COL = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPOT_ROW = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_AXIS_X   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_AXIS_Y   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_AMOUNT   = 3'd4;

  typedef struct packed {
    logic [7:0] pixel_x;
    logic [6:0] pixel_y;
    logic [7:0] pixel_value;
  } pixel_t;

  typedef struct packed {
    logic [7:0] new_value;
    logic       inside_light;
  } result_t;

endpackage
`default_nettype wire

// ----- hdl/elliptic_light_blend.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Elliptic light blend
// Adds a signed elliptical light with linear horizontal falloff to a stream
// of grey pixels, saturating the result to 0..255.
// ----------------------------------------------------------------------------
// The block takes one pixel word in every clock cycle and busy never rises.
// Each word comes out on result with done high, in order; the receiver must
// take it in that cycle. It passes through the seven register stages: the
// offsets from the center, their squares, the two cross products of the
// ellipse test, the ellipse decision, the falloff, the amount multiplier and
// the final saturation. The falloff divider runs beside them in stages two
// to five.
module elliptic_light_blend #(
  parameter int IMAGE_WIDTH  = 160,
  parameter int IMAGE_HEIGHT = 120
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire elb_pkg::pixel_t                pixel,
  output logic                                done,
  output elb_pkg::result_t                    result,
  input  wire logic                           cfg_write,
  input  wire logic [elb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [elb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic signed [9:0] spot_col;
  logic signed [9:0] spot_row;
  logic [6:0]        axis_x;
  logic [6:0]        axis_y;
  logic signed [8:0] amount;
  logic [13:0]       rx_sq;
  logic [13:0]       ry_sq;

  function automatic logic [8:0] div_step(input logic [7:0] r, input logic [7:0] d);
    logic [8:0] t;
    t = {r, 1'b0};
    if (t >= {1'b0, d}) begin
      div_step = {1'b1, 8'(t - {1'b0, d})};
    end else begin
      div_step = {1'b0, t[7:0]};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      spot_col <= '0;
      spot_row <= '0;
      axis_x   <= 7'd1;
      axis_y   <= 7'd1;
      amount   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        elb_pkg::CFG_SPOT_COL: spot_col <= cfg_data;
        elb_pkg::CFG_SPOT_ROW: spot_row <= cfg_data;
        elb_pkg::CFG_AXIS_X:   axis_x   <= cfg_data[6:0];
        elb_pkg::CFG_AXIS_Y:   axis_y   <= cfg_data[6:0];
        elb_pkg::CFG_AMOUNT:   amount   <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rx_sq <= axis_x * axis_x;
    ry_sq <= axis_y * axis_y;
  end

  assign busy = 1'b0;

  logic [7:0] divisor;
  assign divisor = {1'b0, axis_x} + 8'd1;

  // Stage 1: offsets from the center and the coarse range checks.
  logic signed [10:0] dx_c;
  logic signed [10:0] dy_c;
  logic [10:0]        adx_c;
  logic [10:0]        ady_c;
  logic               in_image_c;

  always_comb begin
    dx_c       = $signed({3'b000, pixel.pixel_x}) - $signed({spot_col[9], spot_col});
    dy_c       = $signed({4'b0000, pixel.pixel_y}) - $signed({spot_row[9], spot_row});
    adx_c      = dx_c[10] ? 11'(-dx_c) : 11'(dx_c);
    ady_c      = dy_c[10] ? 11'(-dy_c) : 11'(dy_c);
    in_image_c = (int'(pixel.pixel_x) < IMAGE_WIDTH) && (int'(pixel.pixel_y) < IMAGE_HEIGHT);
  end

  logic       s1_valid;
  logic       s1_cand;
  logic [6:0] s1_adx;
  logic [6:0] s1_ady;
  logic [7:0] s1_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_cand <= in_image_c && (ady_c <= {4'b0000, axis_y}) && (adx_c <= 11'd127);
    s1_adx  <= adx_c[6:0];
    s1_ady  <= ady_c[6:0];
    s1_val  <= pixel.pixel_value;
  end

  // Stage 2: squares and the first two divider steps.
  logic [8:0] s2_st1;
  logic [8:0] s2_st2;

  always_comb begin
    s2_st1 = div_step({1'b0, s1_adx}, divisor);
    s2_st2 = div_step(s2_st1[7:0], divisor);
  end

  logic        s2_valid;
  logic        s2_cand;
  logic        s2_adx0;
  logic [13:0] s2_adx2;
  logic [13:0] s2_rem;
  logic [7:0]  s2_val;
  logic [7:0]  s2_r;
  logic [1:0]  s2_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_cand <= s1_cand;
    s2_adx0 <= (s1_adx == 7'd0);
    s2_adx2 <= s1_adx * s1_adx;
    s2_rem  <= ry_sq - 14'(s1_ady * s1_ady);
    s2_val  <= s1_val;
    s2_r    <= s2_st2[7:0];
    s2_q    <= {s2_st1[8], s2_st2[8]};
  end

  // Stage 3: cross products of the ellipse test, divider steps three and four.
  logic [8:0] s3_st1;
  logic [8:0] s3_st2;

  always_comb begin
    s3_st1 = div_step(s2_r, divisor);
    s3_st2 = div_step(s3_st1[7:0], divisor);
  end

  logic        s3_valid;
  logic        s3_cand;
  logic        s3_adx0;
  logic        s3_ry0;
  logic [27:0] s3_lhs;
  logic [27:0] s3_rhs;
  logic [7:0]  s3_val;
  logic [7:0]  s3_r;
  logic [3:0]  s3_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_cand <= s2_cand;
    s3_adx0 <= s2_adx0;
    s3_ry0  <= (ry_sq == 14'd0);
    s3_lhs  <= s2_adx2 * ry_sq;
    s3_rhs  <= s2_rem * rx_sq;
    s3_val  <= s2_val;
    s3_r    <= s3_st2[7:0];
    s3_q    <= {s2_q, s3_st1[8], s3_st2[8]};
  end

  // Stage 4: ellipse decision, divider steps five and six.
  logic [8:0] s4_st1;
  logic [8:0] s4_st2;

  always_comb begin
    s4_st1 = div_step(s3_r, divisor);
    s4_st2 = div_step(s4_st1[7:0], divisor);
  end

  logic       s4_valid;
  logic       s4_lit;
  logic [7:0] s4_val;
  logic [7:0] s4_r;
  logic [5:0] s4_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_lit <= s3_cand && (s3_ry0 ? s3_adx0 : (s3_lhs <= s3_rhs));
    s4_val <= s3_val;
    s4_r   <= s4_st2[7:0];
    s4_q   <= {s3_q, s4_st1[8], s4_st2[8]};
  end

  // Stage 5: last divider steps and the falloff.
  logic [8:0] s5_st1;
  logic [8:0] s5_st2;

  always_comb begin
    s5_st1 = div_step(s4_r, divisor);
    s5_st2 = div_step(s5_st1[7:0], divisor);
  end

  logic       s5_valid;
  logic       s5_lit;
  logic [7:0] s5_val;
  logic [8:0] s5_falloff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
    s5_lit     <= s4_lit;
    s5_val     <= s4_val;
    s5_falloff <= 9'd256 - {1'b0, s4_q, s5_st1[8], s5_st2[8]};
  end

  // Stage 6: scaled amount.
  logic              s6_valid;
  logic              s6_lit;
  logic [7:0]        s6_val;
  logic signed [18:0] s6_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else begin
      s6_valid <= s5_valid;
    end
    s6_lit  <= s5_lit;
    s6_val  <= s5_val;
    s6_prod <= amount * $signed({1'b0, s5_falloff});
  end

  // Stage 7: division by 256 toward zero, blend and saturation.
  logic signed [18:0] biased_c;
  logic signed [9:0]  add_c;
  logic signed [10:0] sum_c;
  logic [7:0]         sat_c;

  always_comb begin
    biased_c = s6_prod[18] ? (s6_prod + 19'sd255) : s6_prod;
    add_c    = biased_c[17:8];
    sum_c    = $signed({3'b000, s6_val}) + $signed({add_c[9], add_c});
    if (sum_c[10]) begin
      sat_c = 8'd0;
    end else if (sum_c > 11'sd255) begin
      sat_c = 8'd255;
    end else begin
      sat_c = sum_c[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s6_valid;
    end
    result.new_value    <= s6_lit ? sat_c : s6_val;
    result.inside_light <= s6_lit;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##7 done)
    else $error("A started word did not come out after seven cycles.");

  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    (done && !result.inside_light) |-> (result.new_value == $past(pixel.pixel_value, 7)))
    else $error("An unlit word did not keep its grey level.");

  a_lit_in_image: assert property (@(posedge clk) disable iff (rst)
    (done && result.inside_light) |->
      ((int'($past(pixel.pixel_x, 7)) < IMAGE_WIDTH) &&
       (int'($past(pixel.pixel_y, 7)) < IMAGE_HEIGHT)))
    else $error("A word outside the image was lit.");

endmodule
`default_nettype wire
